>>> rtl/xor_convolution_walsh_hadamard_defines.svh
// Assertion macros used by the checker of the xor convolution block.
`ifndef XOR_CONVOLUTION_WALSH_HADAMARD_DEFINES_SVH
`define XOR_CONVOLUTION_WALSH_HADAMARD_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define XCWH_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("xcwh check failed");

// Next-cycle implication, disabled while reset is active.
`define XCWH_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("xcwh check failed");

`endif

>>> rtl/xcwh_pkg.sv
// Shared types and constants of the xor convolution block.
package xcwh_pkg;

  localparam int unsigned DEPTH    = 1024;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned PAIR_W   = IDX_W - 1;
  localparam int unsigned ELEM_W   = 16;
  localparam int unsigned MUL_W    = 27;
  localparam int unsigned DATA_W   = 2 * MUL_W;
  localparam int unsigned RES_W    = 42;
  localparam int unsigned LOG_W    = 4;
  localparam int unsigned CFG_W    = 4;
  localparam logic [LOG_W-1:0] MAX_LOG = 4'd10;

  // Item kind codes on the input channel.
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_RUN   = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_LOG_SIZE  = 1'b0;
  localparam logic CFG_SELF_MODE = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_RUN,
    OP_READ,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic [IDX_W-1:0]         index;
    logic signed [ELEM_W-1:0] a_value;
    logic signed [ELEM_W-1:0] b_value;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_DATA,
    ST_BF_RD,
    ST_BF_WX,
    ST_BF_WY,
    ST_MUL_RD,
    ST_MUL_EX,
    ST_MUL_WR
  } state_e;

endpackage

>>> rtl/xcwh_ram.sv
// Generic RAM with one write port and two registered read ports.
module xcwh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr0_i,
  input  logic [$clog2(Depth)-1:0] raddr1_i,
  output logic [Width-1:0]         rdata0_o,
  output logic [Width-1:0]         rdata1_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

>>> rtl/xcwh_front.sv
// Front end: accepts items, classifies their kind and queues them.
module xcwh_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            kind_i,
  input  logic [xcwh_pkg::IDX_W-1:0]  index_i,
  input  logic signed [xcwh_pkg::ELEM_W-1:0] a_value_i,
  input  logic signed [xcwh_pkg::ELEM_W-1:0] b_value_i,
  output logic                  q_valid_o,
  output xcwh_pkg::item_t       q_item_o,
  input  logic                  q_pop_i
);

  xcwh_pkg::item_t entries_q [2];
  xcwh_pkg::item_t new_item;
  logic            wptr_q, rptr_q;
  logic [1:0]      cnt_q, cnt_d;
  logic            push;

  // Classify the incoming item.
  always_comb begin
    new_item.index   = index_i;
    new_item.a_value = a_value_i;
    new_item.b_value = b_value_i;
    case (kind_i)
      xcwh_pkg::KIND_WRITE: new_item.op = xcwh_pkg::OP_WRITE;
      xcwh_pkg::KIND_RUN:   new_item.op = xcwh_pkg::OP_RUN;
      xcwh_pkg::KIND_READ:  new_item.op = xcwh_pkg::OP_READ;
      default:              new_item.op = xcwh_pkg::OP_NONE;
    endcase
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = entries_q[rptr_q];

  // Occupancy follows pushes and pops.
  always_comb begin
    cnt_d = cnt_q;
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (q_pop_i) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  // Queue payload.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wptr_q] <= new_item;
    end
  end

endmodule

>>> rtl/xcwh_back.sv
// Back end: runs writes, reads and the transform sequence over the two stores.
module xcwh_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [xcwh_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          q_valid_i,
  input  xcwh_pkg::item_t               q_item_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [xcwh_pkg::RES_W-1:0] result_value_o,
  output logic                          is_read_data_o
);

  localparam int unsigned IW = xcwh_pkg::IDX_W;
  localparam int unsigned PW = xcwh_pkg::PAIR_W;
  localparam int unsigned DW = xcwh_pkg::DATA_W;
  localparam int unsigned LW = xcwh_pkg::LOG_W;

  xcwh_pkg::state_e state_q, state_d;
  logic [LW-1:0]  log_q, stage_q, stage_d, log_eff;
  logic           self_q, inv_q, inv_d;
  logic [PW-1:0]  pair_q, pair_d, lo_mask, pair_last;
  logic [IW-1:0]  elem_q, elem_d, len_mask, x_idx, y_idx;
  logic signed [DW-1:0] ta_q, ta_d, tb_q, tb_d, prod_q, prod_d;
  logic signed [DW-1:0] sum_a, dif_a, sum_b, dif_b, ext_a, ext_b;
  logic           out_valid_q, out_valid_d, is_read_q, is_read_d;
  logic signed [xcwh_pkg::RES_W-1:0] result_q, result_d;

  logic           we_a, we_b;
  logic [IW-1:0]  waddr, raddr0, raddr1;
  logic [DW-1:0]  wdata_a, wdata_b, a0, a1, b0, b1;
  logic signed [xcwh_pkg::MUL_W-1:0] mul_l, mul_r;

  // Active length, saturated at the store depth.
  assign log_eff   = (log_q > xcwh_pkg::MAX_LOG) ? xcwh_pkg::MAX_LOG : log_q;
  assign len_mask  = IW'((11'd1 << log_eff) - 11'd1);
  assign pair_last = len_mask[IW-1:1];

  // Butterfly addresses: insert a zero bit at the stage position.
  assign lo_mask = PW'((10'd1 << stage_q) - 10'd1);
  assign x_idx   = {pair_q & ~lo_mask, 1'b0} | {1'b0, pair_q & lo_mask};
  assign y_idx   = x_idx | (IW'(1) << stage_q);

  // Butterfly arithmetic; the inverse halves with floor rounding.
  always_comb begin
    sum_b = signed'(b0) + signed'(b1);
    dif_b = signed'(b0) - signed'(b1);
    if (inv_q) begin
      sum_a = (signed'(a0) + signed'(a1)) >>> 1;
      dif_a = (signed'(a0) - signed'(a1)) >>> 1;
    end else begin
      sum_a = signed'(a0) + signed'(a1);
      dif_a = signed'(a0) - signed'(a1);
    end
  end

  assign ext_a = DW'(q_item_i.a_value);
  assign ext_b = DW'(q_item_i.b_value);
  assign mul_l = a0[xcwh_pkg::MUL_W-1:0];
  assign mul_r = self_q ? a0[xcwh_pkg::MUL_W-1:0] : b0[xcwh_pkg::MUL_W-1:0];

  // Sequencer: next state, store ports and result register.
  always_comb begin
    state_d     = state_q;
    stage_d     = stage_q;
    pair_d      = pair_q;
    elem_d      = elem_q;
    inv_d       = inv_q;
    ta_d        = ta_q;
    tb_d        = tb_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && !out_ready_i;
    result_d    = result_q;
    is_read_d   = is_read_q;
    q_pop_o     = 1'b0;
    we_a        = 1'b0;
    we_b        = 1'b0;
    waddr       = x_idx;
    wdata_a     = sum_a;
    wdata_b     = sum_b;
    raddr0      = x_idx;
    raddr1      = y_idx;
    case (state_q)
      xcwh_pkg::ST_IDLE: begin
        raddr0 = q_item_i.index;
        waddr  = q_item_i.index;
        wdata_a = ext_a;
        wdata_b = ext_b;
        if (q_valid_i && (!out_valid_q || out_ready_i)) begin
          q_pop_o = 1'b1;
          case (q_item_i.op)
            xcwh_pkg::OP_WRITE: begin
              we_a        = 1'b1;
              we_b        = 1'b1;
              out_valid_d = 1'b1;
              result_d    = '0;
              is_read_d   = 1'b0;
            end
            xcwh_pkg::OP_READ: begin
              state_d = xcwh_pkg::ST_RD_DATA;
            end
            xcwh_pkg::OP_RUN: begin
              stage_d = '0;
              pair_d  = '0;
              elem_d  = '0;
              inv_d   = 1'b0;
              state_d = (log_eff == '0) ? xcwh_pkg::ST_MUL_RD : xcwh_pkg::ST_BF_RD;
            end
            default: begin
              out_valid_d = 1'b1;
              result_d    = '0;
              is_read_d   = 1'b0;
            end
          endcase
        end
      end
      xcwh_pkg::ST_RD_DATA: begin
        out_valid_d = 1'b1;
        result_d    = a0[xcwh_pkg::RES_W-1:0];
        is_read_d   = 1'b1;
        state_d     = xcwh_pkg::ST_IDLE;
      end
      xcwh_pkg::ST_BF_RD: begin
        state_d = xcwh_pkg::ST_BF_WX;
      end
      xcwh_pkg::ST_BF_WX: begin
        we_a    = 1'b1;
        we_b    = !inv_q && !self_q;
        ta_d    = dif_a;
        tb_d    = dif_b;
        state_d = xcwh_pkg::ST_BF_WY;
      end
      xcwh_pkg::ST_BF_WY: begin
        we_a    = 1'b1;
        we_b    = !inv_q && !self_q;
        waddr   = y_idx;
        wdata_a = ta_q;
        wdata_b = tb_q;
        state_d = xcwh_pkg::ST_BF_RD;
        if (pair_q == pair_last) begin
          pair_d = '0;
          if (stage_q == log_eff - LW'(1)) begin
            stage_d = '0;
            if (inv_q) begin
              out_valid_d = 1'b1;
              result_d    = '0;
              is_read_d   = 1'b0;
              state_d     = xcwh_pkg::ST_IDLE;
            end else begin
              state_d = xcwh_pkg::ST_MUL_RD;
            end
          end else begin
            stage_d = stage_q + LW'(1);
          end
        end else begin
          pair_d = pair_q + PW'(1);
        end
      end
      xcwh_pkg::ST_MUL_RD: begin
        raddr0  = elem_q;
        state_d = xcwh_pkg::ST_MUL_EX;
      end
      xcwh_pkg::ST_MUL_EX: begin
        prod_d  = DW'(mul_l * mul_r);
        state_d = xcwh_pkg::ST_MUL_WR;
      end
      xcwh_pkg::ST_MUL_WR: begin
        we_a    = 1'b1;
        waddr   = elem_q;
        wdata_a = prod_q;
        state_d = xcwh_pkg::ST_MUL_RD;
        if (elem_q == len_mask) begin
          elem_d = '0;
          inv_d  = 1'b1;
          if (log_eff == '0) begin
            out_valid_d = 1'b1;
            result_d    = '0;
            is_read_d   = 1'b0;
            state_d     = xcwh_pkg::ST_IDLE;
          end else begin
            state_d = xcwh_pkg::ST_BF_RD;
          end
        end else begin
          elem_d = elem_q + IW'(1);
        end
      end
      default: begin
        state_d = xcwh_pkg::ST_IDLE;
      end
    endcase
  end

  // State, configuration and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= xcwh_pkg::ST_IDLE;
      log_q       <= xcwh_pkg::MAX_LOG;
      self_q      <= 1'b0;
      stage_q     <= '0;
      pair_q      <= '0;
      elem_q      <= '0;
      inv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stage_q     <= stage_d;
      pair_q      <= pair_d;
      elem_q      <= elem_d;
      inv_q       <= inv_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          xcwh_pkg::CFG_LOG_SIZE:  log_q  <= cfg_data_i[LW-1:0];
          xcwh_pkg::CFG_SELF_MODE: self_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ta_q      <= ta_d;
    tb_q      <= tb_d;
    prod_q    <= prod_d;
    result_q  <= result_d;
    is_read_q <= is_read_d;
  end

  xcwh_ram #(.Width(DW), .Depth(xcwh_pkg::DEPTH)) u_first_store (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (wdata_a),
    .raddr0_i(raddr0),
    .raddr1_i(raddr1),
    .rdata0_o(a0),
    .rdata1_o(a1)
  );

  xcwh_ram #(.Width(DW), .Depth(xcwh_pkg::DEPTH)) u_second_store (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (wdata_b),
    .raddr0_i(raddr0),
    .raddr1_i(raddr1),
    .rdata0_o(b0),
    .rdata1_o(b1)
  );

  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_q;
  assign is_read_data_o = is_read_q;

endmodule

>>> rtl/xor_convolution_walsh_hadamard.sv
// Top level of the xor (dyadic) convolution engine.
// Usage: items enter on the in_* valid/ready channel; kind 0 writes a_value and
// b_value at index, kind 1 runs the convolution over 2^log_size entries, kind 2
// reads one result element, kind 3 does nothing. Every item gives exactly one
// item on the out_* valid/ready channel; only reads carry data (is_read_data_o).
// Configuration (log_size index 0, self_mode index 1) is written through
// cfg_we_i/cfg_idx_i/cfg_data_i while the block is idle.
// An item waits in the two-entry input queue until the back end is idle and
// the result register is free; a write or kind 3 item then loads the result
// register, and a read first passes through the registered store read.
// A run transforms forward (both stores in parallel, only the first in self
// mode), multiplies pointwise (by the second store, or squares in self mode)
// and runs the inverse on the first store: each butterfly reads two entries,
// then writes them back one per cycle through the single store write port.
// Reset clears control, sets log_size to 10 and clears self_mode; the stores
// are not cleared and must be written before they are read.
// A stalled receiver holds the result register; the queue keeps accepting items
// until it is full, then in_ready_o drops.
module xor_convolution_walsh_hadamard (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [xcwh_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 kind_i,
  input  logic [xcwh_pkg::IDX_W-1:0] index_i,
  input  logic signed [xcwh_pkg::ELEM_W-1:0] a_value_i,
  input  logic signed [xcwh_pkg::ELEM_W-1:0] b_value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [xcwh_pkg::RES_W-1:0] result_value_o,
  output logic                       is_read_data_o
);

  logic            q_valid, q_pop;
  xcwh_pkg::item_t q_item;

  xcwh_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .kind_i    (kind_i),
    .index_i   (index_i),
    .a_value_i (a_value_i),
    .b_value_i (b_value_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  xcwh_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_value_o(result_value_o),
    .is_read_data_o(is_read_data_o)
  );

endmodule

>>> rtl/xcwh_checker.sv
// Port-level checker of the xor convolution block and its bind.
`include "xor_convolution_walsh_hadamard_defines.svh"

module xcwh_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic signed [xcwh_pkg::RES_W-1:0] result_value_o,
  input logic                       is_read_data_o
);

  logic [2:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Items accepted whose result is not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 3'd0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 3'd1;
    end else if (!in_acc && out_acc) begin
      pending_q <= pending_q - 3'd1;
    end
  end

  `XCWH_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(result_value_o) && $stable(is_read_data_o))
  `XCWH_ASSERT_NOW(a_no_data_zero, out_valid_o && !is_read_data_o, result_value_o == '0)
  `XCWH_ASSERT_NOW(a_no_invented, out_valid_o, pending_q != 3'd0)
  `XCWH_ASSERT_NOW(a_bounded, 1'b1, pending_q <= 3'd3)

endmodule

bind xor_convolution_walsh_hadamard xcwh_checker u_xcwh_checker (.*);

>>> bench/tb.sv
// Self-checking testbench of the xor convolution engine with a scoreboard class.
`timescale 1ns / 1ps

module tb;
  import xcwh_pkg::*;

  // Scoreboard: keeps its own copy of both stores and the configuration, and
  // predicts every output item from the input items accepted by the block.
  class conv_scoreboard;
    logic signed [63:0] a_store [DEPTH];
    logic signed [63:0] b_store [DEPTH];
    int unsigned log_sz;
    bit self_sq;
    logic signed [RES_W-1:0] exp_value [$];
    bit exp_is_read [$];
    int errors;
    int reads;
    int runs;
    int items;
    // Writes always start at index zero, so the written entries form a prefix.
    int unsigned filled;

    function new();
      log_sz = 10;
      self_sq = 1'b0;
      errors = 0;
      reads = 0;
      runs = 0;
      items = 0;
      filled = 0;
      for (int i = 0; i < DEPTH; i++) begin
        a_store[i] = '0;
        b_store[i] = '0;
      end
    endfunction

    function void set_config(logic idx, logic [CFG_W-1:0] data);
      if (idx == CFG_LOG_SIZE) log_sz = int'(data);
      else self_sq = data[0];
    endfunction

    // Active length: 2^log_size, saturated at the store depth.
    function int unsigned span();
      int unsigned len;
      len = 1;
      for (int k = 0; k < log_sz; k++) begin
        if (len * 2 > DEPTH) break;
        len = len * 2;
      end
      return len;
    endfunction

    // In-place butterflies over one store; the inverse halves with floor.
    function void butterflies(bit on_b, int unsigned len, bit inverse);
      logic signed [63:0] x, y, s, t;
      for (int unsigned d = 1; d < len; d = d * 2) begin
        for (int unsigned i = 0; i < len; i += 2 * d) begin
          for (int unsigned j = 0; j < d; j++) begin
            x = on_b ? b_store[i+j] : a_store[i+j];
            y = on_b ? b_store[i+j+d] : a_store[i+j+d];
            s = x + y;
            t = x - y;
            if (inverse) begin
              s = s >>> 1;
              t = t >>> 1;
            end
            if (on_b) begin
              b_store[i+j] = s;
              b_store[i+j+d] = t;
            end else begin
              a_store[i+j] = s;
              a_store[i+j+d] = t;
            end
          end
        end
      end
    endfunction

    function void convolve();
      int unsigned len;
      len = span();
      butterflies(1'b0, len, 1'b0);
      if (!self_sq) butterflies(1'b1, len, 1'b0);
      for (int unsigned i = 0; i < len; i++) begin
        if (self_sq) a_store[i] = a_store[i] * a_store[i];
        else a_store[i] = a_store[i] * b_store[i];
      end
      butterflies(1'b0, len, 1'b1);
    endfunction

    // Note one accepted input item and queue the output item it causes.
    function void note_input(logic [1:0] kind, logic [IDX_W-1:0] idx,
                             logic signed [ELEM_W-1:0] a, logic signed [ELEM_W-1:0] b);
      logic signed [RES_W-1:0] value;
      bit rd;
      value = '0;
      rd = 1'b0;
      items++;
      if (kind == KIND_WRITE) begin
        a_store[idx] = 64'(a);
        b_store[idx] = 64'(b);
        if (int'(idx) >= filled) filled = int'(idx) + 1;
      end else if (kind == KIND_RUN) begin
        convolve();
        runs++;
      end else if (kind == KIND_READ) begin
        value = a_store[idx][RES_W-1:0];
        rd = 1'b1;
        reads++;
      end
      exp_value = {exp_value, value};
      exp_is_read = {exp_is_read, rd};
    endfunction

    // Compare one output item with the oldest expectation.
    function void check(logic signed [RES_W-1:0] value, logic rd);
      logic signed [RES_W-1:0] want;
      bit want_rd;
      if (exp_value.size() == 0) begin
        $error("output item with no expectation: result_value %0d", value);
        errors++;
        return;
      end
      want = exp_value.pop_front();
      want_rd = exp_is_read.pop_front();
      if (value !== want) begin
        $error("result_value: expected %0d, actual %0d", want, value);
        errors++;
      end
      if (rd !== want_rd) begin
        $error("is_read_data: expected %0d, actual %0d", want_rd, rd);
        errors++;
      end
    endfunction

    function int pending();
      return exp_value.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic [1:0] kind_i;
  logic [IDX_W-1:0] index_i;
  logic signed [ELEM_W-1:0] a_value_i;
  logic signed [ELEM_W-1:0] b_value_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [RES_W-1:0] result_value_o;
  logic is_read_data_o;

  conv_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int phases;

  xor_convolution_walsh_hadamard DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Generous bound on the whole run.
  initial begin
    #10ms;
    $display("tb failed");
    $finish;
  end

  // Receiver: check accepted output items and stall at random.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check(result_value_o, is_read_data_o);
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Send one item; afterwards the sender may drop in_valid_i and go idle at random.
  task automatic send_item(logic [1:0] kind, logic [IDX_W-1:0] idx,
                           logic signed [ELEM_W-1:0] a, logic signed [ELEM_W-1:0] b);
    in_valid_i <= 1'b1;
    kind_i <= kind;
    index_i <= idx;
    a_value_i <= a;
    b_value_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(kind, idx, a, b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Pause the sender until every expected item has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(logic idx, logic [CFG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_config(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [ELEM_W-1:0] pick_element();
    int r;
    r = $urandom_range(9);
    if (r == 0) return -16'sd32768;
    if (r == 1) return 16'sd32767;
    return ELEM_W'($urandom);
  endfunction

  // One convolution: configure, load the active entries, run, read back.
  // Every active entry is rewritten first so no value can grow out of range.
  // Reads elsewhere stay within the entries written so far.
  task automatic conv_phase(logic [CFG_W-1:0] lg, bit sm, int nreads, bit noise);
    int unsigned len;
    drain();
    write_config(CFG_LOG_SIZE, lg);
    write_config(CFG_SELF_MODE, sm);
    len = sb.span();
    for (int unsigned i = 0; i < len; i++) begin
      send_item(KIND_WRITE, IDX_W'(i), pick_element(), pick_element());
      if (noise && $urandom_range(15) == 0)
        send_item(KIND_NONE, IDX_W'($urandom), ELEM_W'($urandom), ELEM_W'($urandom));
    end
    if (noise && $urandom_range(3) == 0)
      send_item(KIND_READ, IDX_W'($urandom_range(len - 1)), '0, '0);
    send_item(KIND_RUN, IDX_W'($urandom), ELEM_W'($urandom), ELEM_W'($urandom));
    for (int r = 0; r < nreads; r++) begin
      if ($urandom_range(4) == 0)
        send_item(KIND_READ, IDX_W'($urandom_range(sb.filled - 1)), '0, '0);
      else send_item(KIND_READ, IDX_W'($urandom_range(len - 1)), '0, '0);
    end
    phases++;
  endtask

  initial begin
    sb = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    phases = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_LOG_SIZE;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    kind_i = KIND_WRITE;
    index_i = '0;
    a_value_i = '0;
    b_value_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Directed: unused kind, log size zero in both modes, length two with extreme
    // elements, then a long length and reads at its far end.
    send_item(KIND_NONE, '1, 16'sh7fff, -16'sd32768);
    conv_phase(4'd0, 1'b0, 1, 1'b0);
    conv_phase(4'd0, 1'b1, 1, 1'b0);
    drain();
    write_config(CFG_LOG_SIZE, 4'd1);
    write_config(CFG_SELF_MODE, 1'b0);
    send_item(KIND_WRITE, 10'd0, -16'sd32768, -16'sd32768);
    send_item(KIND_WRITE, 10'd1, -16'sd32768, 16'sd32767);
    send_item(KIND_RUN, '0, '0, '0);
    send_item(KIND_READ, 10'd0, '0, '0);
    send_item(KIND_READ, 10'd1, '0, '0);
    conv_phase(4'd1, 1'b1, 2, 1'b0);
    conv_phase(4'd8, 1'b0, 6, 1'b0);
    send_item(KIND_READ, 10'd255, '0, '0);
    send_item(KIND_READ, 10'd128, '0, '0);

    // Random: mostly short lengths, idling pattern changes every phase.
    while (sb.items < 650) begin
      int mode;
      logic [CFG_W-1:0] lg;
      mode = phases % 4;
      send_idle_pct = (mode == 1 || mode == 3) ? ((mode == 3) ? 28 : 63) : 0;
      recv_stall_pct = (mode == 2 || mode == 3) ? ((mode == 3) ? 28 : 63) : 0;
      lg = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(5, 7))
                                    : CFG_W'($urandom_range(0, 4));
      conv_phase(lg, $urandom_range(1), $urandom_range(2, 10), 1'b1);
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d items in %0d phases: %0d convolution runs, %0d reads.",
             sb.items, phases, sb.runs, sb.reads);
    $display("Log sizes 0 to 8, both modes, under four idling patterns.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/xcwh_pkg.sv
rtl/xcwh_ram.sv
rtl/xcwh_front.sv
rtl/xcwh_back.sv
rtl/xor_convolution_walsh_hadamard.sv
rtl/xcwh_checker.sv
bench/tb.sv
